[sv/pdt_pkg.sv]
// Shared constants and codes for the pairwise distance table.
`timescale 1ns / 1ps
`default_nettype none

package pdt_pkg;

    // Fixed widths of the transfer fields
    localparam int OP_W        = 2;
    localparam int ID_W        = 6;
    localparam int DIST_PORT_W = 64;
    localparam int STATUS_W    = 2;

    // Defaults for the top-level parameters
    localparam int MAX_IDS_DEF    = 64;
    localparam int DIST_WIDTH_DEF = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;
    localparam logic [OP_W-1:0] OP_GET   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_ID    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

endpackage

`default_nettype wire

[sv/pdt_slot.sv]
// Triangular index of an unordered ID pair: hi*(hi-1)/2 + lo.
`timescale 1ns / 1ps
`default_nettype none

module pdt_slot #(
    parameter int MAX_IDS = pdt_pkg::MAX_IDS_DEF
) (
    id_a,
    id_b,
    slot
);

    localparam int IDW        = $clog2(MAX_IDS);
    localparam int PAIR_DEPTH = MAX_IDS * (MAX_IDS - 1) / 2;
    localparam int PAW        = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int PW         = 2 * IDW;

    input  wire logic [IDW-1:0] id_a;
    input  wire logic [IDW-1:0] id_b;
    output logic      [PAW-1:0] slot;

    logic [IDW-1:0] lo;
    logic [IDW-1:0] hi;
    logic [PW-1:0]  prod;

    always_comb begin
        lo = (id_a < id_b) ? id_a : id_b;
        hi = (id_a < id_b) ? id_b : id_a;
        // hi is at least 1 for any distinct pair
        prod = PW'(hi) * PW'(hi - 1'b1);
        slot = PAW'((prod >> 1) + PW'(lo));
    end

endmodule

`default_nettype wire

[sv/pairwise_distance_table_top.sv]
// Top level of the pairwise distance table with its ID allocator.
// - Input channel (s_*): one command per transfer. s_operation selects allocate,
//   free, set distance or get distance; s_id_a / s_id_b name the IDs and
//   s_distance_in carries the word written by set.
// - Result channel (m_*): exactly one result transfer per command, in order:
//   m_issued_id (allocate), m_distance_out (get) and m_status.
// - One command is worked on at a time. States from one accept to the next,
//   with the result side free:
//     set, rejected get, allocate from the high-water mark, failed calls:
//       execute, respond
//     get, allocate from the recycled stack: execute, memory read, respond
//     free of an issued ID: execute, a walk over the ID's row and column up
//       to high_water (zeroing its pairs one per step), respond
// - Reset (aresetn low, synchronous) empties the allocator and then runs a
//   clearing pass over the pair store, one word per cycle, over all
//   MAX_IDS*(MAX_IDS-1)/2 words (2016 at 64 IDs); s_ready stays low for it.
// - A stalled receiver holds the result in the output register. One more
//   command is accepted and worked on meanwhile; its result waits until the
//   output register is taken, and only then is the next command accepted.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_distance_table_top #(
    parameter int MAX_IDS    = pdt_pkg::MAX_IDS_DEF,
    parameter int DIST_WIDTH = pdt_pkg::DIST_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pdt_pkg::OP_W-1:0]         s_operation,
    input  wire logic [pdt_pkg::ID_W-1:0]         s_id_a,
    input  wire logic [pdt_pkg::ID_W-1:0]         s_id_b,
    input  wire logic [pdt_pkg::DIST_PORT_W-1:0]  s_distance_in,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [pdt_pkg::ID_W-1:0]         m_issued_id,
    output logic      [pdt_pkg::DIST_PORT_W-1:0]  m_distance_out,
    output logic      [pdt_pkg::STATUS_W-1:0]     m_status
);

    localparam int IDW        = $clog2(MAX_IDS);
    localparam int HWW        = $clog2(MAX_IDS + 1);
    localparam int PAIR_DEPTH = MAX_IDS * (MAX_IDS - 1) / 2;
    localparam int PAW        = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    // width for comparing raw 6-bit IDs against the high-water mark
    localparam int CW         = (HWW > pdt_pkg::ID_W) ? HWW : pdt_pkg::ID_W;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_EXEC     = 7'b0000100,
        S_POP_WAIT = 7'b0001000,
        S_GET_WAIT = 7'b0010000,
        S_WALK     = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    state_t                         state_reg, state_next;
    logic [PAW-1:0]                 clr_addr_reg, clr_addr_next;
    logic [HWW-1:0]                 hw_reg, hw_next;          // IDs ever issued
    logic [HWW-1:0]                 cnt_reg, cnt_next;        // stacked IDs
    logic [IDW-1:0]                 other_reg, other_next;    // free walk index
    logic                           m_valid_reg, m_valid_next;

    // captured command
    logic [pdt_pkg::OP_W-1:0]       op_reg;
    logic [pdt_pkg::ID_W-1:0]       a_reg;
    logic [pdt_pkg::ID_W-1:0]       b_reg;
    logic [DIST_WIDTH-1:0]          dist_reg;

    // result under construction
    logic [IDW-1:0]                 res_issued_reg, res_issued_next;
    logic [DIST_WIDTH-1:0]          res_dist_reg, res_dist_next;
    logic [pdt_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;

    // output register
    logic [pdt_pkg::ID_W-1:0]       out_issued_reg;
    logic [pdt_pkg::DIST_PORT_W-1:0] out_dist_reg;
    logic [pdt_pkg::STATUS_W-1:0]   out_status_reg;

    // ---------------------------------------------------------------------
    // Memories and their ports
    // ---------------------------------------------------------------------
    logic [DIST_WIDTH-1:0]  pair_mem [PAIR_DEPTH];
    logic [IDW-1:0]         stack_mem [MAX_IDS];

    logic                   store_we;
    logic                   store_re;
    logic [PAW-1:0]         store_addr;
    logic [DIST_WIDTH-1:0]  store_wdata;
    logic [DIST_WIDTH-1:0]  store_rd_reg;

    logic                   stack_we;
    logic                   stack_re;
    logic [IDW-1:0]         stack_waddr;
    logic [IDW-1:0]         stack_raddr;
    logic [IDW-1:0]         stack_rd_reg;

    // ---------------------------------------------------------------------
    // Decode helpers
    // ---------------------------------------------------------------------
    logic                   accept;
    logic                   out_free;
    logic [CW-1:0]          a_cmp;
    logic [CW-1:0]          b_cmp;
    logic [CW-1:0]          hw_cmp;
    logic                   a_issued;
    logic                   pair_ok;
    logic [IDW-1:0]         a_id;
    logic [IDW-1:0]         slot_b;
    logic [PAW-1:0]         slot;
    logic                   walk_last;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign a_cmp    = CW'(a_reg);
    assign b_cmp    = CW'(b_reg);
    assign hw_cmp   = CW'(hw_reg);
    assign a_issued = a_cmp < hw_cmp;
    assign pair_ok  = (a_reg != b_reg) && a_issued && (b_cmp < hw_cmp);

    // only meaningful once the IDs have been checked against high water
    assign a_id     = IDW'(a_reg);
    assign slot_b   = (state_reg == S_WALK) ? other_reg : IDW'(b_reg);

    assign walk_last = (HWW'(other_reg) + HWW'(1)) == hw_reg;

    pdt_slot #(
        .MAX_IDS (MAX_IDS)
    ) u_slot (
        .id_a (a_id),
        .id_b (slot_b),
        .slot (slot)
    );

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        hw_next         = hw_reg;
        cnt_next        = cnt_reg;
        other_next      = other_reg;
        m_valid_next    = m_valid_reg;
        res_issued_next = res_issued_reg;
        res_dist_next   = res_dist_reg;
        res_status_next = res_status_reg;

        store_we    = 1'b0;
        store_re    = 1'b0;
        store_addr  = slot;
        store_wdata = '0;
        stack_we    = 1'b0;
        stack_re    = 1'b0;
        stack_waddr = IDW'(cnt_reg);
        stack_raddr = IDW'(cnt_reg - HWW'(1));

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                store_we      = 1'b1;
                store_addr    = clr_addr_reg;
                clr_addr_next = clr_addr_reg + PAW'(1);
                if (clr_addr_reg == PAW'(PAIR_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_issued_next = '0;
                res_dist_next   = '0;
                res_status_next = pdt_pkg::STAT_DONE;
                state_next      = S_RESP;
                case (op_reg)
                    pdt_pkg::OP_ALLOC: begin
                        if (cnt_reg != '0) begin
                            stack_re   = 1'b1;
                            cnt_next   = cnt_reg - HWW'(1);
                            state_next = S_POP_WAIT;
                        end else if (hw_reg < HWW'(MAX_IDS)) begin
                            res_issued_next = IDW'(hw_reg);
                            hw_next         = hw_reg + HWW'(1);
                        end else begin
                            res_status_next = pdt_pkg::STAT_NO_ID;
                        end
                    end
                    pdt_pkg::OP_FREE: begin
                        if (a_issued) begin
                            other_next = '0;
                            state_next = S_WALK;
                        end else begin
                            res_status_next = pdt_pkg::STAT_INVALID;
                        end
                    end
                    pdt_pkg::OP_SET: begin
                        if (pair_ok) begin
                            store_we    = 1'b1;
                            store_wdata = dist_reg;
                        end else begin
                            res_status_next = pdt_pkg::STAT_INVALID;
                        end
                    end
                    pdt_pkg::OP_GET: begin
                        if (pair_ok) begin
                            store_re   = 1'b1;
                            state_next = S_GET_WAIT;
                        end else begin
                            res_status_next = pdt_pkg::STAT_INVALID;
                        end
                    end
                    default: begin
                        res_status_next = pdt_pkg::STAT_INVALID;
                    end
                endcase
            end

            S_POP_WAIT: begin
                res_issued_next = stack_rd_reg;
                state_next      = S_RESP;
            end

            S_GET_WAIT: begin
                res_dist_next = store_rd_reg;
                state_next    = S_RESP;
            end

            S_WALK: begin
                // zero the pairing of the freed ID with each issued ID
                store_we   = (other_reg != a_id);
                other_next = other_reg + IDW'(1);
                if (walk_last) begin
                    if (cnt_reg < HWW'(MAX_IDS)) begin
                        stack_we = 1'b1;
                        cnt_next = cnt_reg + HWW'(1);
                    end else begin
                        res_status_next = pdt_pkg::STAT_OVERFLOW;
                    end
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            hw_reg       <= '0;
            cnt_reg      <= '0;
            other_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            hw_reg       <= hw_next;
            cnt_reg      <= cnt_next;
            other_reg    <= other_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_operation;
            a_reg    <= s_id_a;
            b_reg    <= s_id_b;
            dist_reg <= s_distance_in[DIST_WIDTH-1:0];
        end
        res_issued_reg <= res_issued_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_RESP) && out_free) begin
            out_issued_reg <= pdt_pkg::ID_W'(res_issued_reg);
            out_dist_reg   <= pdt_pkg::DIST_PORT_W'(res_dist_reg);
            out_status_reg <= res_status_reg;
        end
    end

    // pair store: one access per cycle, registered read
    always_ff @(posedge aclk) begin
        if (store_we) begin
            pair_mem[store_addr] <= store_wdata;
        end
        if (store_re) begin
            store_rd_reg <= pair_mem[store_addr];
        end
    end

    // recycled ID stack
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= a_id;
        end
        if (stack_re) begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_issued_id    = out_issued_reg;
    assign m_distance_out = out_dist_reg;
    assign m_status       = out_status_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= HWW'(MAX_IDS)) && (hw_reg <= HWW'(MAX_IDS)))
        else $error("allocator counters out of range");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted command not executed");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (HWW'(other_reg) < hw_reg))
        else $error("free walk beyond high water");

    a_hw_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR) |=> (hw_reg >= $past(hw_reg)))
        else $error("high water decreased");

    a_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_IDLE) || (state_reg == S_RESP)) |-> (!store_we && !stack_we))
        else $error("memory write outside command execution");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the pairwise distance table and its ID allocator.
`timescale 1ns / 1ps

module testbench;
    import pdt_pkg::*;

    // Block configuration: the defaults of the top level
    localparam int MAX_IDS       = MAX_IDS_DEF;
    localparam int PAIR_SLOTS    = MAX_IDS * (MAX_IDS - 1) / 2;

    // Run shape
    localparam int RANDOM_ITEMS  = 850;
    localparam int MAX_GAP       = 19;
    localparam int HOLD_CYCLES   = 300;
    // Worst free walk plus margin; waited once all results are in
    localparam int SETTLE_CYCLES = MAX_IDS + 8;
    // Hard limit on the run, well above the slowest correct run including the
    // clearing pass after reset.
    localparam int CYCLE_LIMIT   = 600000;

    // One expected result transfer
    typedef struct packed {
        logic [ID_W-1:0]        issued_id;
        logic [DIST_PORT_W-1:0] distance;
        logic [STATUS_W-1:0]    status;
    } reply_t;

    // ------------------------------------------------------------------
    // Block ports; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_operation   = OP_ALLOC;
    logic [ID_W-1:0]        s_id_a        = '0;
    logic [ID_W-1:0]        s_id_b        = '0;
    logic [DIST_PORT_W-1:0] s_distance_in = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [ID_W-1:0]        m_issued_id;
    logic [DIST_PORT_W-1:0] m_distance_out;
    logic [STATUS_W-1:0]    m_status;

    pairwise_distance_table_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_id_a         (s_id_a),
        .s_id_b         (s_id_b),
        .s_distance_in  (s_distance_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_issued_id    (m_issued_id),
        .m_distance_out (m_distance_out),
        .m_status       (m_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Mirror of the block's state, advanced at every accepted command
    // ------------------------------------------------------------------
    logic [DIST_PORT_W-1:0] dist_mirror [PAIR_SLOTS];
    logic [ID_W-1:0]        freed_ids   [MAX_IDS];
    int                     hw_mark     = 0;    // IDs ever issued
    int                     freed_count = 0;    // depth of the recycle stack

    // Results still owed by the block, oldest first
    reply_t pending_replies[$];

    // Bookkeeping
    int mismatches    = 0;
    int replies_seen  = 0;
    int sent_by_op[4] = '{0, 0, 0, 0};
    int no_id_seen    = 0;
    int overflow_seen = 0;

    // Idling controls shared by the tests, the sender and the receiver
    bit src_idle     = 1'b0;
    bit sink_idle    = 1'b0;
    int hold_request = 0;

    // Triangular storage: unordered pair (lo, hi), lo < hi, at hi*(hi-1)/2 + lo
    function automatic int pair_slot(input int a, input int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return hi * (hi - 1) / 2 + lo;
    endfunction

    // A pair is usable when its IDs differ and both have been issued
    function automatic bit pair_live(input int a, input int b);
        return a != b && a < hw_mark && b < hw_mark;
    endfunction

    // Works out the result of one command and updates the mirror
    function automatic reply_t predict_reply(input logic [OP_W-1:0] op,
                                             input logic [ID_W-1:0] a,
                                             input logic [ID_W-1:0] b,
                                             input logic [DIST_PORT_W-1:0] word);
        reply_t r;
        logic [ID_W-1:0] fresh;
        r = '{issued_id: '0, distance: '0, status: STAT_DONE};
        fresh = ID_W'(hw_mark);
        case (op)
            OP_ALLOC: begin
                // LIFO reuse first, then the high-water mark
                if (freed_count > 0) begin
                    freed_count--;
                    r.issued_id = freed_ids[freed_count];
                end else if (hw_mark < MAX_IDS) begin
                    r.issued_id = fresh;
                    hw_mark++;
                end else begin
                    r.status = STAT_NO_ID;
                end
            end
            OP_FREE: begin
                if (int'(a) >= hw_mark) begin
                    r.status = STAT_INVALID;
                end else begin
                    // Row and column are cleared even when the push is dropped
                    for (int other = 0; other < hw_mark; other++) begin
                        if (other != int'(a))
                            dist_mirror[pair_slot(a, other)] = '0;
                    end
                    if (freed_count < MAX_IDS) begin
                        freed_ids[freed_count] = a;
                        freed_count++;
                    end else begin
                        r.status = STAT_OVERFLOW;
                    end
                end
            end
            OP_SET: begin
                if (pair_live(a, b))
                    dist_mirror[pair_slot(a, b)] = word;
                else
                    r.status = STAT_INVALID;
            end
            default: begin
                if (pair_live(a, b))
                    r.distance = dist_mirror[pair_slot(a, b)];
                else
                    r.status = STAT_INVALID;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // An issued ID when asked for one and any exists, else any ID at all
    function automatic logic [ID_W-1:0] pick_id(input bit live);
        if (live && hw_mark > 0)
            return ID_W'($urandom_range(0, hw_mark - 1));
        return ID_W'($urandom_range(0, MAX_IDS - 1));
    endfunction

    task automatic pick_pair(input bit live, output logic [ID_W-1:0] a,
                             output logic [ID_W-1:0] b);
        a = pick_id(live);
        b = pick_id(live);
        if (live && a == b && hw_mark > 1)
            b = ID_W'((int'(a) + 1) % hw_mark);
    endtask

    // Distance words, with all-zero and all-one words now and then
    function automatic logic [DIST_PORT_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one command and returns at the edge where it transfers. Valid
    // stays high on return so a back-to-back command needs no dip.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] a,
                            input logic [ID_W-1:0] b,
                            input logic [DIST_PORT_W-1:0] word);
        int gap;
        reply_t due;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_id_a        <= a;
        s_id_b        <= b;
        s_distance_in <= word;
        do @(posedge aclk); while (s_ready !== 1'b1);
        due = predict_reply(op, a, b, word);
        pending_replies = {pending_replies, due};
        sent_by_op[op]++;
    endtask

    // Sender goes quiet until every owed result has come back
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls per transfer, plus the long hold-off
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_reply();
        reply_t want;
        replies_seen++;
        if (pending_replies.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing owed, id %0d dist %h status %0d",
                     $time, m_issued_id, m_distance_out, m_status);
        end else begin
            want = pending_replies.pop_front();
            compare_field("issued_id", 64'(want.issued_id), 64'(m_issued_id));
            compare_field("distance_out", want.distance, m_distance_out);
            compare_field("status", 64'(want.status), 64'(m_status));
            if (m_status === STAT_NO_ID)
                no_id_seen++;
            if (m_status === STAT_OVERFLOW)
                overflow_seen++;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                check_reply();
                stall_left = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            // a hold-off asked for by a test is counted out here
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked commands: empty allocator, pair order, rejections, reuse
    task automatic test_basic_ops();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        // nothing issued yet, so every ID is unknown
        send_cmd(OP_GET,  6'd0,  6'd1,  '1);
        send_cmd(OP_SET,  6'd0,  6'd1,  '1);
        send_cmd(OP_FREE, 6'd0,  6'd0,  '0);
        // fresh IDs 0, 1, 2 from the high-water mark
        repeat (3) send_cmd(OP_ALLOC, 6'd63, 6'd63, '1);
        send_cmd(OP_SET,  6'd0,  6'd1,  '1);
        send_cmd(OP_SET,  6'd2,  6'd1,  64'h8000_0000_0000_0001);
        send_cmd(OP_SET,  6'd0,  6'd2,  64'h5555_aaaa_0f0f_f0f0);
        // reversed order reads the same word
        send_cmd(OP_GET,  6'd1,  6'd0,  '0);
        send_cmd(OP_GET,  6'd1,  6'd2,  '0);
        send_cmd(OP_GET,  6'd2,  6'd0,  '0);
        // equal pair, unissued ID high and low
        send_cmd(OP_GET,  6'd2,  6'd2,  '0);
        send_cmd(OP_SET,  6'd63, 6'd0,  '1);
        send_cmd(OP_GET,  6'd0,  6'd3,  '0);
        // free clears the row and column of ID 1
        send_cmd(OP_FREE, 6'd1,  6'd63, '1);
        send_cmd(OP_GET,  6'd0,  6'd1,  '0);
        send_cmd(OP_GET,  6'd2,  6'd1,  '0);
        send_cmd(OP_FREE, 6'd63, 6'd0,  '0);
        // reuse from the stack, then a fresh one
        send_cmd(OP_ALLOC, 6'd0, 6'd0, '0);
        send_cmd(OP_ALLOC, 6'd0, 6'd0, '0);
        // a repeated free is stacked twice and issued twice
        send_cmd(OP_FREE, 6'd0, 6'd0, '0);
        send_cmd(OP_FREE, 6'd0, 6'd0, '0);
        send_cmd(OP_ALLOC, 6'd0, 6'd0, '0);
        send_cmd(OP_ALLOC, 6'd0, 6'd0, '0);
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering, so the block fills
    // and drops s_ready; then the sender waits for everything owed.
    task automatic test_backpressure();
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        src_idle     = 1'b0;
        sink_idle    = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 16; n++) begin
            pick_pair(1'b1, a, b);
            send_cmd((n % 2) ? OP_GET : OP_SET, a, b, rand_word());
        end
        wait_drain();
    endtask

    // Mostly well-formed commands on issued IDs, some noise; idling mode
    // is drawn anew every hundred transfers so there are stretches without gaps.
    task automatic test_random_traffic();
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic [OP_W-1:0] op;
        int sel;
        int mode;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                mode      = $urandom_range(0, 3);
                src_idle  = mode[0];
                sink_idle = mode[1];
            end
            sel = $urandom_range(0, 99);
            if (sel < 25)
                op = OP_ALLOC;
            else if (sel < 40)
                op = OP_FREE;
            else if (sel < 70)
                op = OP_SET;
            else
                op = OP_GET;
            pick_pair($urandom_range(0, 99) < 85, a, b);
            send_cmd(op, a, b, rand_word());
        end
        wait_drain();
    endtask

    // Drain the stack and the high-water mark, then ask for more
    task automatic test_id_exhaustion();
        src_idle  = 1'($urandom_range(0, 1));
        sink_idle = 1'($urandom_range(0, 1));
        while (freed_count > 0 || hw_mark < MAX_IDS)
            send_cmd(OP_ALLOC, pick_id(1'b0), pick_id(1'b0), rand_word());
        repeat (2) send_cmd(OP_ALLOC, 6'd0, 6'd0, '0);
        // top corner of the table
        send_cmd(OP_SET, 6'd63, 6'd62, rand_word());
        send_cmd(OP_SET, 6'd0,  6'd63, '1);
        send_cmd(OP_GET, 6'd62, 6'd63, '0);
        send_cmd(OP_GET, 6'd63, 6'd0,  '0);
        send_cmd(OP_GET, 6'd63, 6'd63, '0);
        wait_drain();
    endtask

    // Free until the recycle stack is full, then once more
    task automatic test_stack_overflow();
        src_idle  = 1'b1;
        sink_idle = 1'b0;
        while (freed_count < MAX_IDS)
            send_cmd(OP_FREE, pick_id(1'b1), pick_id(1'b0), rand_word());
        // dropped push, but the row is still cleared
        send_cmd(OP_SET,  6'd63, 6'd1,  '1);
        send_cmd(OP_FREE, 6'd63, 6'd0,  '0);
        send_cmd(OP_GET,  6'd1,  6'd63, '0);
        repeat (3) send_cmd(OP_ALLOC, 6'd0, 6'd0, '0);
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        // pair store reads as zero after the clearing pass that follows reset
        for (int i = 0; i < PAIR_SLOTS; i++)
            dist_mirror[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_backpressure();
        test_random_traffic();
        test_id_exhaustion();
        test_stack_overflow();

        // let any stray transfer show up before deciding
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d allocate, %0d free, %0d set, %0d get; %0d results checked",
                 sent_by_op[OP_ALLOC], sent_by_op[OP_FREE], sent_by_op[OP_SET],
                 sent_by_op[OP_GET], replies_seen);
        $display("Pool exhausted %0d times, stack overflowed %0d times, %0d mismatches",
                 no_id_seen, overflow_seen, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timed out after %0d cycles, %0d results outstanding",
                 cycles, pending_replies.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
